// ===== rtl/tpdm_pkg.sv =====
package tpdm_pkg;

	// Event kinds carried on the event channel.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_RUN   = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	// Configuration register indexes and port widths.
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] REG_PERIOD_TARGET = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DEADLINE_TOL  = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [15:0] PERIOD_TARGET_RST = 16'd0;
	localparam logic [7:0]  DEADLINE_TOL_RST  = 8'd5;

	localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] period_target;
		logic [7:0]  deadline_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] time_stamp;
		logic [31:0] run_time;
	} evt_t;

	typedef struct packed {
		logic [31:0] measured_period;
		logic        miss_now;
		logic [31:0] shortest_period;
		logic [31:0] longest_period;
		logic [31:0] miss_count;
		logic [31:0] cycle_count;
		logic [31:0] window_busy;
		logic [63:0] lifetime_busy;
		logic [31:0] worst_run;
		logic [31:0] best_run;
	} res_t;

endpackage

// ===== rtl/tpdm_evt_if.sv =====
interface tpdm_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] time_stamp;
	logic [31:0] run_time;

	modport source (output valid, output kind, output time_stamp, output run_time,
		input ready);
	modport sink (input valid, input kind, input time_stamp, input run_time,
		output ready);
endinterface

// ===== rtl/tpdm_res_if.sv =====
interface tpdm_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] measured_period;
	logic        miss_now;
	logic [31:0] shortest_period;
	logic [31:0] longest_period;
	logic [31:0] miss_count;
	logic [31:0] cycle_count;
	logic [31:0] window_busy;
	logic [63:0] lifetime_busy;
	logic [31:0] worst_run;
	logic [31:0] best_run;

	modport source (output valid, output measured_period, output miss_now,
		output shortest_period, output longest_period, output miss_count,
		output cycle_count, output window_busy, output lifetime_busy,
		output worst_run, output best_run, input ready);
	modport sink (input valid, input measured_period, input miss_now,
		input shortest_period, input longest_period, input miss_count,
		input cycle_count, input window_busy, input lifetime_busy,
		input worst_run, input best_run, output ready);
endinterface

// ===== rtl/tpdm_cfg_if.sv =====
interface tpdm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tpdm_pkg::CfgIdxW-1:0]  index;
	logic [tpdm_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/task_period_deadline_monitor_core.sv =====
// Per-task period and deadline monitor. Each event request (cycle start with a
// millisecond time stamp, runtime report in microseconds, or window close)
// yields exactly one result request carrying a full statistics snapshot. The
// block takes one event per clock cycle while the result channel keeps up.
// An accepted event is held in the input register, where the state update and
// snapshot are formed. Its result is then offered from the result register.
// Throughput is set by the single statistics update stage, which handles one
// event per cycle while the result register is free or being emptied.
// While a finished result waits to be taken, the input register can still
// accept one further event. After that the event channel stalls until the
// result is taken.
// Configuration registers may be written at any time via the configuration
// channel, which is always ready, but should only change while no event is in
// flight.
module task_period_deadline_monitor_core (
	input  logic       clk,
	input  logic       arst_n,
	tpdm_evt_if.sink   evt,
	tpdm_res_if.source res,
	tpdm_cfg_if.sink   cfg
);

	tpdm_pkg::cfg_t cfg_cur;
	tpdm_pkg::evt_t evt_s1;
	tpdm_pkg::res_t snapshot;
	tpdm_pkg::res_t res_q;
	logic           valid_s1;
	logic           res_valid_q;
	logic           advance;
	logic           evt_take;

	assign cfg.ready = 1'b1;

	tpdm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_cur)
	);

	// Input stage moves on whenever the result register is free or being emptied.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign evt_take  = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			evt_s1.kind       <= evt.kind;
			evt_s1.time_stamp <= evt.time_stamp;
			evt_s1.run_time   <= evt.run_time;
		end
	end

	tpdm_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.evt_s1   (evt_s1),
		.cfg      (cfg_cur),
		.snapshot (snapshot)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= snapshot;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.measured_period = res_q.measured_period;
	assign res.miss_now        = res_q.miss_now;
	assign res.shortest_period = res_q.shortest_period;
	assign res.longest_period  = res_q.longest_period;
	assign res.miss_count      = res_q.miss_count;
	assign res.cycle_count     = res_q.cycle_count;
	assign res.window_busy     = res_q.window_busy;
	assign res.lifetime_busy   = res_q.lifetime_busy;
	assign res.worst_run       = res_q.worst_run;
	assign res.best_run        = res_q.best_run;

endmodule

// ===== rtl/tpdm_cfg_regs.sv =====
module tpdm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tpdm_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [tpdm_pkg::CfgDataW-1:0] wr_data,
	output tpdm_pkg::cfg_t                cfg
);

	tpdm_pkg::cfg_t cfg_q;

	// Register writes; an index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_target      <= tpdm_pkg::PERIOD_TARGET_RST;
			cfg_q.deadline_tolerance <= tpdm_pkg::DEADLINE_TOL_RST;
		end else if (wr_en) begin
			case (wr_index)
				tpdm_pkg::REG_PERIOD_TARGET: begin
					cfg_q.period_target <= wr_data[15:0];
				end
				tpdm_pkg::REG_DEADLINE_TOL: begin
					cfg_q.deadline_tolerance <= wr_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tpdm_stats.sv =====
module tpdm_stats (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  tpdm_pkg::evt_t evt_s1,
	input  tpdm_pkg::cfg_t cfg,
	output tpdm_pkg::res_t snapshot
);

	logic [31:0] previous_start_q;
	logic [31:0] period_low_q;
	logic [31:0] period_high_q;
	logic [31:0] misses_q;
	logic [31:0] cycles_q;
	logic [31:0] window_sum_q;
	logic [63:0] lifetime_sum_q;
	logic [31:0] run_high_q;
	logic [31:0] run_low_q;

	logic [31:0] period;
	logic        measured;
	logic [16:0] limit;
	logic        miss;
	logic        is_start;
	logic        is_run;
	logic        is_close;

	logic [31:0] post_low;
	logic [31:0] post_high;
	logic [31:0] post_misses;
	logic [31:0] post_cycles;
	logic [31:0] post_window;
	logic [63:0] post_lifetime;
	logic [31:0] post_run_high;
	logic [31:0] post_run_low;

	assign is_start = (evt_s1.kind == tpdm_pkg::KIND_START);
	assign is_run   = (evt_s1.kind == tpdm_pkg::KIND_RUN);
	assign is_close = (evt_s1.kind == tpdm_pkg::KIND_CLOSE);

	// Period since the previous start, wrapping, and the deadline test.
	assign measured = is_start && (previous_start_q != '0);
	assign period   = evt_s1.time_stamp - previous_start_q;
	assign limit    = {1'b0, cfg.period_target} + {9'd0, cfg.deadline_tolerance};
	assign miss     = measured && (cfg.period_target != '0) && (period > {15'd0, limit});

	// Statistics after the event; a close or an unused kind leaves them as they are.
	always_comb begin
		post_low      = period_low_q;
		post_high     = period_high_q;
		post_misses   = misses_q;
		post_cycles   = cycles_q;
		post_window   = window_sum_q;
		post_lifetime = lifetime_sum_q;
		post_run_high = run_high_q;
		post_run_low  = run_low_q;
		if (is_start) begin
			post_cycles = cycles_q + 32'd1;
			if (measured && (period > period_high_q)) begin
				post_high = period;
			end
			if (measured && (period < period_low_q)) begin
				post_low = period;
			end
			if (miss) begin
				post_misses = misses_q + 32'd1;
			end
		end else if (is_run) begin
			post_window   = window_sum_q + evt_s1.run_time;
			post_lifetime = lifetime_sum_q + {32'd0, evt_s1.run_time};
			if (evt_s1.run_time > run_high_q) begin
				post_run_high = evt_s1.run_time;
			end
			if (evt_s1.run_time < run_low_q) begin
				post_run_low = evt_s1.run_time;
			end
		end
	end

	// Snapshot of the statistics; a close shows the window before it is cleared.
	always_comb begin
		snapshot.measured_period = measured ? period : '0;
		snapshot.miss_now        = miss;
		snapshot.shortest_period = (post_low == tpdm_pkg::ALL_ONES32) ? '0 : post_low;
		snapshot.longest_period  = post_high;
		snapshot.miss_count      = post_misses;
		snapshot.cycle_count     = post_cycles;
		snapshot.window_busy     = post_window;
		snapshot.lifetime_busy   = post_lifetime;
		snapshot.worst_run       = post_run_high;
		snapshot.best_run        = post_run_low;
	end

	// State update as the event leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_start_q <= '0;
			period_low_q     <= tpdm_pkg::ALL_ONES32;
			period_high_q    <= '0;
			misses_q         <= '0;
			cycles_q         <= '0;
			window_sum_q     <= '0;
			lifetime_sum_q   <= '0;
			run_high_q       <= '0;
			run_low_q        <= tpdm_pkg::ALL_ONES32;
		end else if (advance) begin
			lifetime_sum_q <= post_lifetime;
			run_high_q     <= post_run_high;
			run_low_q      <= post_run_low;
			if (is_start) begin
				previous_start_q <= evt_s1.time_stamp;
			end
			if (is_close) begin
				period_low_q  <= tpdm_pkg::ALL_ONES32;
				period_high_q <= '0;
				misses_q      <= '0;
				cycles_q      <= '0;
				window_sum_q  <= '0;
			end else begin
				period_low_q  <= post_low;
				period_high_q <= post_high;
				misses_q      <= post_misses;
				cycles_q      <= post_cycles;
				window_sum_q  <= post_window;
			end
		end
	end

endmodule

// ===== rtl/tpdm_checker.sv =====
module tpdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] measured_period,
	input logic        miss_now,
	input logic [31:0] shortest_period,
	input logic [31:0] longest_period,
	input logic [31:0] miss_count
);

	// A result that is not taken stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	// A miss always comes with a nonzero measured period.
	a_miss_period: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && miss_now |-> measured_period != '0)
		else $error("deadline miss without a measured period");

	// A miss is already included in the window miss count.
	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && miss_now |-> miss_count != '0)
		else $error("deadline miss not counted");

	// The window maximum bounds both the minimum and the period just measured.
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (longest_period >= shortest_period)
			&& (longest_period >= measured_period))
		else $error("window period bounds inconsistent");

endmodule

bind task_period_deadline_monitor_core tpdm_checker u_tpdm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.measured_period (res.measured_period),
	.miss_now        (res.miss_now),
	.shortest_period (res.shortest_period),
	.longest_period  (res.longest_period),
	.miss_count      (res.miss_count)
);

// ===== dv/task_period_deadline_monitor_core_tb.sv =====
`timescale 1ns / 100ps

module task_period_deadline_monitor_core_tb;

	// The fourth event kind has no meaning; the block answers it with a plain snapshot.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RESULT_LATENCY = 2;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_EVENTS = 220;

	logic clk;
	logic arst_n;

	tpdm_evt_if evt_bus ();
	tpdm_res_if res_bus ();
	tpdm_cfg_if cfg_bus ();

	task_period_deadline_monitor_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the monitor's configuration and statistics.
	logic [15:0] target_ms;
	logic [7:0]  slack_ms;
	logic [31:0] last_start;
	logic [31:0] win_min_period;
	logic [31:0] win_max_period;
	logic [31:0] win_misses;
	logic [31:0] win_cycles;
	logic [31:0] win_busy;
	logic [63:0] life_busy;
	logic [31:0] worst_seen;
	logic [31:0] best_seen;

	tpdm_pkg::res_t snapshot_queue[$];
	int   mismatch_count;
	int   burst_left;
	bit   tx_free_flow = 1'b1;
	bit   rx_free_flow = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4_000_000;
		$display("task_period_deadline_monitor_core regression: fail");
		$finish;
	end

	// Result receiver: ready follows a 16-bit pattern that is redrawn each time round.
	// Bit 0 is always set, so ready is high at least once in every round of the pattern.
	initial begin : receiver_stall
		logic [15:0] stall_pattern;
		int phase;
		res_bus.ready <= 1'b0;
		stall_pattern = 16'hFFFF;
		phase = 0;
		forever begin
			@(posedge clk);
			if (phase == 0) begin
				if (rx_free_flow)
					stall_pattern = 16'hFFFF;
				else if ($urandom_range(0, 3) == 0)
					stall_pattern = 16'($urandom & $urandom) | 16'h0001;
				else
					stall_pattern = 16'($urandom) | 16'h0001;
			end
			res_bus.ready <= stall_pattern[phase];
			phase = (phase + 1) % 16;
		end
	end

	// Applies one event to the shadow statistics and returns the snapshot it should produce.
	function automatic tpdm_pkg::res_t monitor_update(input tpdm_pkg::evt_t ev);
		tpdm_pkg::res_t snap;
		logic [31:0] period;
		logic miss;
		period = '0;
		miss = 1'b0;
		case (ev.kind)
			tpdm_pkg::KIND_START: begin
				// A stored start of zero means there is nothing to measure from.
				if (last_start != 32'd0) begin
					period = ev.time_stamp - last_start;
					if (period > win_max_period) win_max_period = period;
					if (period < win_min_period) win_min_period = period;
					if (target_ms != 16'd0 &&
						period > ({16'd0, target_ms} + {24'd0, slack_ms})) begin
						win_misses++;
						miss = 1'b1;
					end
				end
				last_start = ev.time_stamp;
				win_cycles++;
			end
			tpdm_pkg::KIND_RUN: begin
				win_busy += ev.run_time;
				life_busy += {32'd0, ev.run_time};
				if (ev.run_time > worst_seen) worst_seen = ev.run_time;
				if (ev.run_time < best_seen) best_seen = ev.run_time;
			end
			default: ;
		endcase
		snap.measured_period = period;
		snap.miss_now        = miss;
		snap.shortest_period = (win_min_period == tpdm_pkg::ALL_ONES32) ? 32'd0 :
			win_min_period;
		snap.longest_period  = win_max_period;
		snap.miss_count      = win_misses;
		snap.cycle_count     = win_cycles;
		snap.window_busy     = win_busy;
		snap.lifetime_busy   = life_busy;
		snap.worst_run       = worst_seen;
		snap.best_run        = best_seen;
		// A window close reports first and clears afterwards.
		if (ev.kind == tpdm_pkg::KIND_CLOSE) begin
			win_busy       = '0;
			win_cycles     = '0;
			win_min_period = tpdm_pkg::ALL_ONES32;
			win_max_period = '0;
			win_misses     = '0;
		end
		return snap;
	endfunction

	function automatic tpdm_pkg::evt_t mk_event(input logic [1:0] kind,
		input logic [31:0] stamp, input logic [31:0] run);
		tpdm_pkg::evt_t ev;
		ev.kind       = kind;
		ev.time_stamp = stamp;
		ev.run_time   = run;
		return ev;
	endfunction

	// Sends one event request, idling between bursts unless the sender is in free flow.
	// Valid stays high after acceptance so that back-to-back requests need no toggle.
	task automatic send_event(input tpdm_pkg::evt_t ev);
		int gap;
		if (!tx_free_flow && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			evt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		evt_bus.valid      <= 1'b1;
		evt_bus.kind       <= ev.kind;
		evt_bus.time_stamp <= ev.time_stamp;
		evt_bus.run_time   <= ev.run_time;
		do @(posedge clk); while (!evt_bus.ready);
		snapshot_queue.push_back(monitor_update(ev));
	endtask

	// Drops valid and waits until every outstanding result has been taken.
	task automatic wait_idle();
		evt_bus.valid <= 1'b0;
		burst_left = 0;
		while (snapshot_queue.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	// Writes both configuration registers back to back; only called while idle.
	task automatic apply_config(input logic [15:0] target, input logic [7:0] slack);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= tpdm_pkg::REG_PERIOD_TARGET;
		cfg_bus.data  <= target;
		do @(posedge clk); while (!cfg_bus.ready);
		target_ms = target;
		cfg_bus.index <= tpdm_pkg::REG_DEADLINE_TOL;
		cfg_bus.data  <= {8'd0, slack};
		do @(posedge clk); while (!cfg_bus.ready);
		slack_ms = slack;
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	// Compares every accepted result request with the oldest predicted snapshot.
	always @(posedge clk) begin : result_check
		tpdm_pkg::res_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (snapshot_queue.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual period %0h",
					$time, res_bus.measured_period);
			end else begin
				want = snapshot_queue.pop_front();
				check_field("measured_period", 64'(want.measured_period),
					64'(res_bus.measured_period));
				check_field("miss_now", 64'(want.miss_now), 64'(res_bus.miss_now));
				check_field("shortest_period", 64'(want.shortest_period),
					64'(res_bus.shortest_period));
				check_field("longest_period", 64'(want.longest_period),
					64'(res_bus.longest_period));
				check_field("miss_count", 64'(want.miss_count), 64'(res_bus.miss_count));
				check_field("cycle_count", 64'(want.cycle_count), 64'(res_bus.cycle_count));
				check_field("window_busy", 64'(want.window_busy), 64'(res_bus.window_busy));
				check_field("lifetime_busy", want.lifetime_busy, res_bus.lifetime_busy);
				check_field("worst_run", 64'(want.worst_run), 64'(res_bus.worst_run));
				check_field("best_run", 64'(want.best_run), 64'(res_bus.best_run));
			end
		end
	end

	// Reset configuration: target zero means no deadline is ever missed.
	task automatic test_reset_defaults();
		send_event(mk_event(KIND_UNUSED, 32'd0, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_RUN, 32'd0, 32'd7));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd1000, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd1500, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_CLOSE, 32'd0, 32'd0));
	endtask

	// A start with a zero time stamp is measured, but then suppresses the next measurement.
	task automatic test_zero_stamp();
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd0, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd40, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd90, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_CLOSE, 32'd0, 32'd0));
	endtask

	// Periods wrap modulo 2^32; a period of all ones leaves the minimum reading zero.
	task automatic test_period_wrap();
		send_event(mk_event(tpdm_pkg::KIND_START, tpdm_pkg::ALL_ONES32, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'h0000_001F, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd5, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_CLOSE, 32'd0, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd4, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_CLOSE, 32'd0, 32'd0));
	endtask

	// A miss needs the period strictly above target plus tolerance, at both ends of the range.
	task automatic test_deadline_limits();
		wait_idle();
		apply_config(16'd100, 8'd5);
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd1000, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd1105, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd1211, 32'd0));
		wait_idle();
		apply_config(16'hFFFF, 8'hFF);
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd2000, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd67790, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_START, 32'd133581, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_CLOSE, 32'd0, 32'd0));
	endtask

	// Run time extremes drive the best and worst run and wrap the window sum.
	task automatic test_runtime_extremes();
		send_event(mk_event(tpdm_pkg::KIND_RUN, 32'd0, 32'd0));
		send_event(mk_event(tpdm_pkg::KIND_RUN, 32'd0, tpdm_pkg::ALL_ONES32));
		send_event(mk_event(tpdm_pkg::KIND_RUN, 32'd0, tpdm_pkg::ALL_ONES32));
		send_event(mk_event(tpdm_pkg::KIND_CLOSE, 32'd0, 32'd0));
	endtask

	// Random traffic over several configurations, with periods clustered around the deadline.
	task automatic test_random_traffic();
		tpdm_pkg::evt_t ev;
		int pick;
		int sel;
		logic [15:0] tgt;
		logic [7:0] tol;
		logic [31:0] limit_ms;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					tgt = 16'd0;
					tol = 8'd0;
				end
				1: begin
					tgt = 16'hFFFF;
					tol = 8'hFF;
				end
				2: begin
					tgt = 16'd1;
					tol = 8'd0;
				end
				default: begin
					tgt = 16'($urandom_range(1, 2000));
					tol = 8'($urandom_range(0, 255));
				end
			endcase
			wait_idle();
			apply_config(tgt, tol);
			tx_free_flow = (ph == 0);
			rx_free_flow = (ph == 0 || ph == 3);
			limit_ms = {16'd0, tgt} + {24'd0, tol};
			repeat (PHASE_EVENTS) begin
				// Fields the kind does not use carry noise.
				ev = mk_event(tpdm_pkg::KIND_START, $urandom, $urandom);
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					sel = $urandom_range(0, 9);
					if (sel == 1)
						ev.time_stamp = '0;
					else if (sel > 1 && tgt == 16'd0)
						ev.time_stamp = last_start + 32'($urandom_range(0, 300));
					else if (sel > 1)
						ev.time_stamp = last_start + limit_ms - 32'd3 +
							32'($urandom_range(0, 6));
				end else if (pick < 87) begin
					ev.kind = tpdm_pkg::KIND_RUN;
					sel = $urandom_range(0, 9);
					if (sel == 0)
						ev.run_time = '0;
					else if (sel == 1)
						ev.run_time = tpdm_pkg::ALL_ONES32;
					else if (sel > 4)
						ev.run_time = 32'($urandom_range(0, 5000));
				end else if (pick < 96) begin
					ev.kind = tpdm_pkg::KIND_CLOSE;
				end else begin
					ev.kind = KIND_UNUSED;
				end
				send_event(ev);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		evt_bus.valid      <= 1'b0;
		evt_bus.kind       <= tpdm_pkg::KIND_START;
		evt_bus.time_stamp <= '0;
		evt_bus.run_time   <= '0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= tpdm_pkg::REG_PERIOD_TARGET;
		cfg_bus.data       <= '0;
		target_ms      = tpdm_pkg::PERIOD_TARGET_RST;
		slack_ms       = tpdm_pkg::DEADLINE_TOL_RST;
		last_start     = '0;
		win_min_period = tpdm_pkg::ALL_ONES32;
		win_max_period = '0;
		win_misses     = '0;
		win_cycles     = '0;
		win_busy       = '0;
		life_busy      = '0;
		worst_seen     = '0;
		best_seen      = tpdm_pkg::ALL_ONES32;
		mismatch_count = 0;
		burst_left     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_zero_stamp();
		test_period_wrap();
		test_deadline_limits();
		test_runtime_extremes();
		test_random_traffic();
		wait_idle();

		if (mismatch_count == 0 && snapshot_queue.size() == 0)
			$display("task_period_deadline_monitor_core regression: pass");
		else
			$display("task_period_deadline_monitor_core regression: fail");
		$finish;
	end

endmodule
